// ===== src/psd_pkg.sv =====
// shared widths for the point to segment squared distance block
package psd_pkg;

    localparam int COORD_W = 16;  // Q12.4 coordinate
    localparam int DIFF_W  = 17;  // difference of two coordinates
    localparam int SQ_W    = 34;  // product of two differences
    localparam int LEN_W   = 33;  // squared segment length
    localparam int DOT_W   = 35;  // signed dot product
    localparam int MAG_W   = 16;  // magnitude of a difference
    localparam int OFF_W   = 18;  // nearest point coordinate
    localparam int ERR_W   = 19;  // point minus nearest point
    localparam int ERRSQ_W = 38;  // square of that error
    localparam int DIST_W  = 33;  // squared distance, Q.8

endpackage

// ===== src/psd_query_if.sv =====
// query channel: point and segment end points
interface psd_query_if import psd_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (
        output valid, point_x, point_y, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, start_x, start_y, end_x, end_y,
        output ready
    );

endinterface

// ===== src/psd_result_if.sv =====
// result channel: squared distance and zero-length flag
interface psd_result_if import psd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] dist_sq;
    logic              degenerate;

    modport source (
        output valid, dist_sq, degenerate,
        input  ready
    );

    modport sink (
        input  valid, dist_sq, degenerate,
        output ready
    );

endinterface

// ===== src/point_segment_distance_squared_top.sv =====
// Squared distance from a Q12.4 point to a Q12.4 segment, in unsigned Q.8. The projection
// parameter t = dot(P-S, E-S) / |E-S|^2 is clamped to [0,1] and cut to FRAC_BITS fraction
// bits; the nearest point is rounded to Q12.4. A zero-length segment gives the squared
// distance to its start and sets degenerate. One item enters per clock and one result
// leaves per clock while the output is taken; the restoring divider resolves one quotient
// bit per pipeline stage. Every stage holds its item while the next one is full and cannot
// move on, so empty stages still take items while the output waits to be taken.
module point_segment_distance_squared_top
    import psd_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    psd_query_if.sink     query,
    psd_result_if.source  result
);

    localparam int NST     = FRAC_BITS + 9;
    localparam int T_W     = FRAC_BITS + 1;
    localparam int PROD_W  = T_W + MAG_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int ST_CLS  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_MUL  = FRAC_BITS + 4;
    localparam int ST_RND  = FRAC_BITS + 5;
    localparam int ST_ERR  = FRAC_BITS + 6;
    localparam int ST_SQ   = FRAC_BITS + 7;
    localparam int ST_OUT  = FRAC_BITS + 8;

    localparam logic [RND_W-1:0] HALF  = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [T_W-1:0]   T_ONE = T_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [LEN_W-1:0]          len2;
        logic [LEN_W-1:0]          rem;
        logic [FRAC_BITS-1:0]      quo;
        logic                      degen;
        logic                      zero;
        logic                      full;
    } div_t;

    // stage handshake
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || result.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = en[0] ? query.valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign query.ready = en[0];

    // stage 0: differences
    logic signed [COORD_W-1:0] s1_px_reg, s1_py_reg, s1_sx_reg, s1_sy_reg;
    logic signed [DIFF_W-1:0]  s1_dx_reg, s1_dy_reg, s1_qx_reg, s1_qy_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_px_reg <= query.point_x;
            s1_py_reg <= query.point_y;
            s1_sx_reg <= query.start_x;
            s1_sy_reg <= query.start_y;
            s1_dx_reg <= DIFF_W'(query.end_x) - DIFF_W'(query.start_x);
            s1_dy_reg <= DIFF_W'(query.end_y) - DIFF_W'(query.start_y);
            s1_qx_reg <= DIFF_W'(query.point_x) - DIFF_W'(query.start_x);
            s1_qy_reg <= DIFF_W'(query.point_y) - DIFF_W'(query.start_y);
        end
    end

    // stage 1: products
    logic signed [COORD_W-1:0] s2_px_reg, s2_py_reg, s2_sx_reg, s2_sy_reg;
    logic signed [DIFF_W-1:0]  s2_dx_reg, s2_dy_reg;
    logic signed [SQ_W-1:0]    s2_dxx_reg, s2_dyy_reg, s2_qxdx_reg, s2_qydy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_dxx_reg  <= SQ_W'(s1_dx_reg) * SQ_W'(s1_dx_reg);
            s2_dyy_reg  <= SQ_W'(s1_dy_reg) * SQ_W'(s1_dy_reg);
            s2_qxdx_reg <= SQ_W'(s1_qx_reg) * SQ_W'(s1_dx_reg);
            s2_qydy_reg <= SQ_W'(s1_qy_reg) * SQ_W'(s1_dy_reg);
        end
    end

    // stage 2: squared length and dot product
    logic signed [COORD_W-1:0] s3_px_reg, s3_py_reg, s3_sx_reg, s3_sy_reg;
    logic signed [DIFF_W-1:0]  s3_dx_reg, s3_dy_reg;
    logic [LEN_W-1:0]          s3_len2_reg;
    logic signed [DOT_W-1:0]   s3_dot_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_px_reg   <= s2_px_reg;
            s3_py_reg   <= s2_py_reg;
            s3_sx_reg   <= s2_sx_reg;
            s3_sy_reg   <= s2_sy_reg;
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_len2_reg <= LEN_W'(s2_dxx_reg) + LEN_W'(s2_dyy_reg);
            s3_dot_reg  <= DOT_W'(s2_qxdx_reg) + DOT_W'(s2_qydy_reg);
        end
    end

    // stage 3: clamp decision and divider setup
    div_t cls_reg;
    div_t cls_next;
    logic dot_pos;
    logic dot_ge_len;

    always_comb
    begin
        dot_pos    = !s3_dot_reg[DOT_W-1] && (s3_dot_reg != '0);
        dot_ge_len = !s3_dot_reg[DOT_W-1] &&
                     (s3_dot_reg[DOT_W-2:0] >= {1'b0, s3_len2_reg});
        cls_next.px    = s3_px_reg;
        cls_next.py    = s3_py_reg;
        cls_next.sx    = s3_sx_reg;
        cls_next.sy    = s3_sy_reg;
        cls_next.dx    = s3_dx_reg;
        cls_next.dy    = s3_dy_reg;
        cls_next.len2  = s3_len2_reg;
        cls_next.degen = (s3_len2_reg == '0);
        // a zero-length segment takes the start point, same as t = 0
        cls_next.zero  = (s3_len2_reg == '0) || !dot_pos;
        cls_next.full  = (s3_len2_reg != '0) && dot_pos && dot_ge_len;
        cls_next.rem   = (dot_pos && !dot_ge_len) ? s3_dot_reg[LEN_W-1:0] : '0;
        cls_next.quo   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CLS])
        begin
            cls_reg <= cls_next;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    div_t div_reg [FRAC_BITS];

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        div_t             src;
        div_t             stage_next;
        logic [LEN_W:0]   shifted;
        logic             take;

        if (i == 0)
        begin : g_first
            assign src = cls_reg;
        end
        else
        begin : g_rest
            assign src = div_reg[i-1];
        end

        always_comb
        begin
            shifted    = {src.rem, 1'b0};
            take       = (shifted >= {1'b0, src.len2});
            stage_next = src;
            stage_next.rem = take ? LEN_W'(shifted - {1'b0, src.len2})
                                  : shifted[LEN_W-1:0];
            stage_next.quo = {src.quo[FRAC_BITS-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+i])
            begin
                div_reg[i] <= stage_next;
            end
        end
    end

    // offset products t * |d|
    div_t                      dv;
    logic [T_W-1:0]            t_val;
    logic [MAG_W-1:0]          mag_x, mag_y;
    logic [PROD_W-1:0]         m1_prod_x_reg, m1_prod_y_reg;
    logic                      m1_neg_x_reg, m1_neg_y_reg, m1_degen_reg;
    logic signed [COORD_W-1:0] m1_px_reg, m1_py_reg, m1_sx_reg, m1_sy_reg;

    always_comb
    begin
        dv = div_reg[FRAC_BITS-1];
        if (dv.zero)
        begin
            t_val = '0;
        end
        else if (dv.full)
        begin
            t_val = T_ONE;
        end
        else
        begin
            t_val = {1'b0, dv.quo};
        end
        mag_x = dv.dx[DIFF_W-1] ? MAG_W'(-dv.dx) : dv.dx[MAG_W-1:0];
        mag_y = dv.dy[DIFF_W-1] ? MAG_W'(-dv.dy) : dv.dy[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            m1_prod_x_reg <= PROD_W'(t_val) * PROD_W'(mag_x);
            m1_prod_y_reg <= PROD_W'(t_val) * PROD_W'(mag_y);
            m1_neg_x_reg  <= dv.dx[DIFF_W-1];
            m1_neg_y_reg  <= dv.dy[DIFF_W-1];
            m1_degen_reg  <= dv.degen;
            m1_px_reg     <= dv.px;
            m1_py_reg     <= dv.py;
            m1_sx_reg     <= dv.sx;
            m1_sy_reg     <= dv.sy;
        end
    end

    // round half away from zero and place the nearest point
    logic [RND_W-1:0]          rnd_x, rnd_y;
    logic signed [OFF_W-1:0]   off_x, off_y;
    logic signed [OFF_W-1:0]   m2_cx_reg, m2_cy_reg;
    logic signed [COORD_W-1:0] m2_px_reg, m2_py_reg;
    logic                      m2_degen_reg;

    always_comb
    begin
        rnd_x = {1'b0, m1_prod_x_reg} + HALF;
        rnd_y = {1'b0, m1_prod_y_reg} + HALF;
        off_x = signed'({1'b0, rnd_x[FRAC_BITS+DIFF_W-1:FRAC_BITS]});
        off_y = signed'({1'b0, rnd_y[FRAC_BITS+DIFF_W-1:FRAC_BITS]});
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_RND])
        begin
            m2_cx_reg    <= OFF_W'(m1_sx_reg) + (m1_neg_x_reg ? -off_x : off_x);
            m2_cy_reg    <= OFF_W'(m1_sy_reg) + (m1_neg_y_reg ? -off_y : off_y);
            m2_px_reg    <= m1_px_reg;
            m2_py_reg    <= m1_py_reg;
            m2_degen_reg <= m1_degen_reg;
        end
    end

    // error vector
    logic signed [ERR_W-1:0] m3_ex_reg, m3_ey_reg;
    logic                    m3_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_ERR])
        begin
            m3_ex_reg    <= ERR_W'(m2_px_reg) - ERR_W'(m2_cx_reg);
            m3_ey_reg    <= ERR_W'(m2_py_reg) - ERR_W'(m2_cy_reg);
            m3_degen_reg <= m2_degen_reg;
        end
    end

    // squares
    logic signed [ERRSQ_W-1:0] m4_sqx_reg, m4_sqy_reg;
    logic                      m4_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            m4_sqx_reg   <= ERRSQ_W'(m3_ex_reg) * ERRSQ_W'(m3_ex_reg);
            m4_sqy_reg   <= ERRSQ_W'(m3_ey_reg) * ERRSQ_W'(m3_ey_reg);
            m4_degen_reg <= m3_degen_reg;
        end
    end

    // output register
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_degen_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_dist_reg  <= DIST_W'(m4_sqx_reg) + DIST_W'(m4_sqy_reg);
            out_degen_reg <= m4_degen_reg;
        end
    end

    assign result.valid      = v_reg[NST-1];
    assign result.dist_sq    = out_dist_reg;
    assign result.degenerate = out_degen_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the point to segment squared distance block
module tb_top;
    import psd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = FRAC_BITS + 9;
    localparam int CYCLE_CAP  = 200000;
    localparam int IDLE_PCT   = 9;

    typedef struct {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } query_t;

    typedef struct {
        logic [DIST_W-1:0] dist_sq;
        logic              degenerate;
    } dist_t;

    logic clk;
    logic rst_n;

    psd_query_if  query ();
    psd_result_if result ();

    point_segment_distance_squared_top #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result)
    );

    dist_t  pending_dist_q[$];
    dist_t  want_dist;
    int     mismatch_cnt;
    int     cycle_cnt;
    bit     src_idle_en;
    bit     sink_idle_en;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // half away from zero rounding of t * d, t in Q.FRAC_BITS
    function automatic longint round_offset(longint t, longint d);
        longint mag;
        longint r;
        mag = (d < 0) ? -d : d;
        r = (t * mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (d < 0) ? -r : r;
    endfunction

    function automatic dist_t predict_dist(query_t q);
        dist_t  r;
        longint px, py, sx, sy, dx, dy, qx, qy;
        longint len2, dot, t, cx, cy;
        px = longint'(q.point_x);
        py = longint'(q.point_y);
        sx = longint'(q.start_x);
        sy = longint'(q.start_y);
        dx = longint'(q.end_x) - sx;
        dy = longint'(q.end_y) - sy;
        qx = px - sx;
        qy = py - sy;
        len2 = dx * dx + dy * dy;
        if (len2 == 0)
        begin
            r.dist_sq    = DIST_W'(qx * qx + qy * qy);
            r.degenerate = 1'b1;
            return r;
        end
        dot = qx * dx + qy * dy;
        if (dot <= 0)
            t = 0;
        else if (dot >= len2)
            t = longint'(1) <<< FRAC_BITS;
        else
            t = (dot <<< FRAC_BITS) / len2;
        cx = sx + round_offset(t, dx);
        cy = sy + round_offset(t, dy);
        r.dist_sq    = DIST_W'((px - cx) * (px - cx) + (py - cy) * (py - cy));
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic query_t make_query(int px, int py, int sx, int sy, int ex, int ey);
        query_t q;
        q.point_x = COORD_W'(px);
        q.point_y = COORD_W'(py);
        q.start_x = COORD_W'(sx);
        q.start_y = COORD_W'(sy);
        q.end_x   = COORD_W'(ex);
        q.end_y   = COORD_W'(ey);
        return q;
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c,
                                                           int span);
        return COORD_W'(int'(c) + $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic query_t random_query(int span);
        query_t q;
        q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 5))
            0: ;
            1:
            begin
                // zero-length segment
                q.end_x = q.start_x;
                q.end_y = q.start_y;
            end
            2:
            begin
                q.point_x = edge_coord();
                q.point_y = edge_coord();
                q.start_x = edge_coord();
                q.start_y = edge_coord();
                q.end_x   = edge_coord();
                q.end_y   = edge_coord();
            end
            default:
            begin
                // short segment with the point close by
                q.end_x   = near_coord(q.start_x, span);
                q.end_y   = near_coord(q.start_y, span);
                q.point_x = near_coord(q.start_x, 2 * span);
                q.point_y = near_coord(q.start_y, 2 * span);
            end
        endcase
        return q;
    endfunction

    task automatic send_query(input query_t q);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            query.valid <= 1'b0;
            @(negedge clk);
        end
        query.valid   <= 1'b1;
        query.point_x <= q.point_x;
        query.point_y <= q.point_y;
        query.start_x <= q.start_x;
        query.start_y <= q.start_y;
        query.end_x   <= q.end_x;
        query.end_y   <= q.end_y;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    endtask

    task automatic test_directed();
        send_query(make_query(0, 0, 0, 0, 0, 0));
        send_query(make_query(-32768, -32768, 32767, 32767, 32767, 32767));
        send_query(make_query(32767, 32767, -32768, -32768, -32768, -32768));
        send_query(make_query(-32768, 32767, -32768, -32768, 32767, 32767));
        send_query(make_query(32767, -32768, -32768, 32767, 32767, -32768));
        // projection before the start
        send_query(make_query(-100, 5, 0, 0, 100, 0));
        // projection beyond the end
        send_query(make_query(300, -7, 0, 0, 100, 0));
        // projection exactly on the end
        send_query(make_query(100, 40, 0, 0, 100, 0));
        // perpendicular foot exactly on the start
        send_query(make_query(0, 40, 0, 0, 100, 0));
        send_query(make_query(50, 30, 0, 0, 100, 0));
        send_query(make_query(7, 50, 3, -20, 3, 90));
        // rounding of a half offset, both directions
        send_query(make_query(1, 0, 0, 0, 1, 1));
        send_query(make_query(-1, 0, 0, 0, -1, -1));
        send_query(make_query(3, 0, 0, 0, 3, 7));
        send_query(make_query(-3, 5, 0, 0, -3, -7));
        // point on the segment
        send_query(make_query(20, 20, -40, -40, 60, 60));
        send_query(make_query(32767, -32768, -32768, -32768, 32767, 32767));
        send_query(make_query(-32768, 32767, 32767, -32768, -32768, 32767));
        send_query(make_query(0, 0, -32768, -32768, 32767, 32767));
        send_query(make_query(-1, -1, -1, -1, -1, -1));
        send_query(make_query(12345, -23456, -5, 9, 11, -3));
        send_query(make_query(-21846, 21845, 21845, -21846, 1, 0));
    endtask

    task automatic test_random(input int count, input int span);
        for (int i = 0; i < count; i++)
            send_query(random_query(span));
    endtask

    task automatic test_no_idle(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random(count, 512);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // expected results from every accepted item
    always @(posedge clk)
    begin
        if (rst_n && query.valid && query.ready)
            pending_dist_q.insert(pending_dist_q.size(),
                                  predict_dist('{query.point_x, query.point_y,
                                                 query.start_x, query.start_y,
                                                 query.end_x, query.end_y}));
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_dist_q.size() == 0)
                report_mismatch($sformatf("unexpected result dist_sq=%0d degenerate=%0b",
                                          result.dist_sq, result.degenerate));
            else
            begin
                want_dist = pending_dist_q.pop_front();
                if (result.dist_sq !== want_dist.dist_sq
                    || result.degenerate !== want_dist.degenerate)
                    report_mismatch($sformatf(
                        "dist_sq exp %0d got %0d, degenerate exp %0b got %0b",
                        want_dist.dist_sq, result.dist_sq,
                        want_dist.degenerate, result.degenerate));
            end
        end
    end

    always @(negedge clk)
        result.ready <= !sink_idle_en || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("FAIL point_segment_distance_squared_top");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        query.valid   = 1'b0;
        query.point_x = '0;
        query.point_y = '0;
        query.start_x = '0;
        query.start_y = '0;
        query.end_x   = '0;
        query.end_y   = '0;
        result.ready  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(200, 64);
        test_no_idle(150);
        test_random(180, 4096);
        query.valid <= 1'b0;

        while (pending_dist_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASS point_segment_distance_squared_top");
        else
            $display("FAIL point_segment_distance_squared_top");
        $finish;
    end

endmodule
